### rtl/array_store_sort_search_macros.svh
// Assertion macros shared by the array store modules.
// Depends on nothing; the macros expand to nothing when SYNTHESIS is defined.
`ifndef ARRAY_STORE_SORT_SEARCH_MACROS_SVH
`define ARRAY_STORE_SORT_SEARCH_MACROS_SVH
`ifndef SYNTHESIS
// The property must hold at every rising clock edge outside reset.
`define SRT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
// The expression must never be true at a rising clock edge outside reset.
`define SRT_ASSERT_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) \
    else $error("forbidden condition seen");
`else
`define SRT_ASSERT(lbl, clk, rstn, prop)
`define SRT_ASSERT_NEVER(lbl, clk, rstn, prop)
`endif
`endif

### rtl/arrsrt_pkg.sv
// Package of the array store: field widths, operation codes, register map and
// the command and status structs between controller and datapath. No dependencies.
`default_nettype none

package arrsrt_pkg;

  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned INDEX_W = 6;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned FLAGS_W = 3;
  localparam int unsigned IN_TDATA_W = 40;
  localparam int unsigned APB_AW  = 3;
  localparam int unsigned APB_DW  = 32;

  localparam logic [COUNT_W-1:0] ELEM_COUNT_RESET = 7'd64;
  localparam logic REG_ELEM_COUNT = 1'b0;

  localparam logic [FUNC_W-1:0] FUNC_WRITE   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ    = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_FILL    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_SEARCH  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_REVERSE = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_SORT    = 3'd5;

  typedef enum logic [1:0] {
    RA_I     = 2'd0,
    RA_J     = 2'd1,
    RA_INDEX = 2'd2
  } rsel_e;

  typedef enum logic [1:0] {
    WA_I     = 2'd0,
    WA_J     = 2'd1,
    WA_INDEX = 2'd2
  } wsel_e;

  typedef enum logic [1:0] {
    WD_VALUE = 2'd0,
    WD_A     = 2'd1,
    WD_RDATA = 2'd2,
    WD_ZERO  = 2'd3
  } wdsel_e;

  typedef struct packed {
    logic   latch;
    logic   push;
    logic   i_clr;
    logic   i_inc;
    logic   j_clr;
    logic   j_ld_i1;
    logic   j_ld_last;
    logic   j_inc;
    logic   j_dec;
    logic   re;
    logic   stream;
    rsel_e  rsel;
    logic   we;
    wsel_e  wsel;
    wdsel_e wdsel;
    logic   a_ld;
    logic   rd_ld;
    logic   err_set;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              idx_ok;
    logic              n_zero;
    logic              n_lt2;
    logic              i_next_lt_n;
    logic              i_lt_j;
    logic              j_at_last;
    logic              clr_last;
    logic              out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

### rtl/arrsrt_ctrl.sv
// Controller of the array store: one-hot state machine that sequences every operation.
// Depends on arrsrt_pkg and array_store_sort_search_macros.svh.
`default_nettype none
`include "array_store_sort_search_macros.svh"

module arrsrt_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  arrsrt_pkg::ctrl_sts_t sts_i,
  output arrsrt_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic [16:0] {
    S_CLEAR      = 17'b00000000000000001,
    S_IDLE       = 17'b00000000000000010,
    S_DISP       = 17'b00000000000000100,
    S_RD_CAP     = 17'b00000000000001000,
    S_FILL       = 17'b00000000000010000,
    S_SRCH_IN    = 17'b00000000000100000,
    S_SRCH_DRAIN = 17'b00000000001000000,
    S_REV_RI     = 17'b00000000010000000,
    S_REV_RJ     = 17'b00000000100000000,
    S_REV_WI     = 17'b00000001000000000,
    S_REV_WJ     = 17'b00000010000000000,
    S_SORT_RI    = 17'b00000100000000000,
    S_SORT_LI    = 17'b00001000000000000,
    S_SORT_IN    = 17'b00010000000000000,
    S_SORT_DRAIN = 17'b00100000000000000,
    S_SORT_WB    = 17'b01000000000000000,
    S_DONE       = 17'b10000000000000000
  } state_e;

  state_e state_q, state_d;
  arrsrt_pkg::ctrl_cmd_t cmd;

  assign in_ready_o = (state_q == S_IDLE);
  assign cmd_o      = cmd;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    unique case (state_q)
      // Zero the whole store once after reset, one entry a cycle.
      S_CLEAR: begin
        cmd.we    = 1'b1;
        cmd.wsel  = arrsrt_pkg::WA_I;
        cmd.wdsel = arrsrt_pkg::WD_ZERO;
        cmd.i_inc = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.latch = 1'b1;
          cmd.i_clr = 1'b1;
          cmd.j_clr = 1'b1;
          state_d   = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts_i.func)
          arrsrt_pkg::FUNC_WRITE: begin
            if (sts_i.idx_ok) begin
              cmd.we    = 1'b1;
              cmd.wsel  = arrsrt_pkg::WA_INDEX;
              cmd.wdsel = arrsrt_pkg::WD_VALUE;
            end else begin
              cmd.err_set = 1'b1;
            end
            state_d = S_DONE;
          end
          arrsrt_pkg::FUNC_READ: begin
            if (sts_i.idx_ok) begin
              cmd.re   = 1'b1;
              cmd.rsel = arrsrt_pkg::RA_INDEX;
              state_d  = S_RD_CAP;
            end else begin
              cmd.err_set = 1'b1;
              state_d     = S_DONE;
            end
          end
          arrsrt_pkg::FUNC_FILL: begin
            state_d = sts_i.n_zero ? S_DONE : S_FILL;
          end
          arrsrt_pkg::FUNC_SEARCH: begin
            state_d = sts_i.n_zero ? S_DONE : S_SRCH_IN;
          end
          arrsrt_pkg::FUNC_REVERSE: begin
            cmd.j_ld_last = 1'b1;
            state_d       = sts_i.n_lt2 ? S_DONE : S_REV_RI;
          end
          arrsrt_pkg::FUNC_SORT: begin
            state_d = S_SORT_RI;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_RD_CAP: begin
        cmd.rd_ld = 1'b1;
        state_d   = S_DONE;
      end
      S_FILL: begin
        cmd.we    = 1'b1;
        cmd.wsel  = arrsrt_pkg::WA_J;
        cmd.wdsel = arrsrt_pkg::WD_VALUE;
        cmd.j_inc = 1'b1;
        if (sts_i.j_at_last) begin
          state_d = S_DONE;
        end
      end
      S_SRCH_IN: begin
        cmd.re     = 1'b1;
        cmd.stream = 1'b1;
        cmd.rsel   = arrsrt_pkg::RA_J;
        cmd.j_inc  = 1'b1;
        if (sts_i.j_at_last) begin
          state_d = S_SRCH_DRAIN;
        end
      end
      S_SRCH_DRAIN: begin
        state_d = S_DONE;
      end
      S_REV_RI: begin
        if (sts_i.i_lt_j) begin
          cmd.re   = 1'b1;
          cmd.rsel = arrsrt_pkg::RA_I;
          state_d  = S_REV_RJ;
        end else begin
          state_d = S_DONE;
        end
      end
      S_REV_RJ: begin
        cmd.re   = 1'b1;
        cmd.rsel = arrsrt_pkg::RA_J;
        cmd.a_ld = 1'b1;
        state_d  = S_REV_WI;
      end
      S_REV_WI: begin
        cmd.we    = 1'b1;
        cmd.wsel  = arrsrt_pkg::WA_I;
        cmd.wdsel = arrsrt_pkg::WD_RDATA;
        state_d   = S_REV_WJ;
      end
      S_REV_WJ: begin
        cmd.we    = 1'b1;
        cmd.wsel  = arrsrt_pkg::WA_J;
        cmd.wdsel = arrsrt_pkg::WD_A;
        cmd.i_inc = 1'b1;
        cmd.j_dec = 1'b1;
        state_d   = S_REV_RI;
      end
      S_SORT_RI: begin
        if (sts_i.i_next_lt_n) begin
          cmd.re      = 1'b1;
          cmd.rsel    = arrsrt_pkg::RA_I;
          cmd.j_ld_i1 = 1'b1;
          state_d     = S_SORT_LI;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SORT_LI: begin
        cmd.a_ld = 1'b1;
        state_d  = S_SORT_IN;
      end
      S_SORT_IN: begin
        cmd.re     = 1'b1;
        cmd.stream = 1'b1;
        cmd.rsel   = arrsrt_pkg::RA_J;
        cmd.j_inc  = 1'b1;
        if (sts_i.j_at_last) begin
          state_d = S_SORT_DRAIN;
        end
      end
      S_SORT_DRAIN: begin
        state_d = S_SORT_WB;
      end
      S_SORT_WB: begin
        cmd.we    = 1'b1;
        cmd.wsel  = arrsrt_pkg::WA_I;
        cmd.wdsel = arrsrt_pkg::WD_A;
        cmd.i_inc = 1'b1;
        state_d   = S_SORT_RI;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd.push = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  `SRT_ASSERT(a_accept_to_disp, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> (state_q == S_DISP))
  `SRT_ASSERT(a_sort_wb_in_range, clk_i, rst_ni, (state_q == S_SORT_WB) |-> sts_i.i_next_lt_n)
  `SRT_ASSERT(a_rev_pair_ordered, clk_i, rst_ni, (state_q == S_REV_WJ) |-> sts_i.i_lt_j)

endmodule

`default_nettype wire

### rtl/arrsrt_dpath.sv
// Datapath of the array store: entry memory, loop counters, compare logic and the
// output register. Depends on arrsrt_pkg and array_store_sort_search_macros.svh.
`default_nettype none
`include "array_store_sort_search_macros.svh"

module arrsrt_dpath #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  arrsrt_pkg::ctrl_cmd_t               cmd_i,
  output arrsrt_pkg::ctrl_sts_t               sts_o,
  input  logic [arrsrt_pkg::COUNT_W-1:0]      elem_count_i,
  input  logic [arrsrt_pkg::FUNC_W-1:0]       in_func_i,
  input  logic [arrsrt_pkg::INDEX_W-1:0]      in_index_i,
  input  logic [arrsrt_pkg::DATA_W-1:0]       in_value_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [arrsrt_pkg::DATA_W-1:0]       out_data_o,
  output logic [arrsrt_pkg::FLAGS_W-1:0]      out_flags_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = (AW + 1 > arrsrt_pkg::COUNT_W) ? AW + 1 : arrsrt_pkg::COUNT_W;
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
  localparam logic [CW-1:0] CLR_LAST = CW'(DEPTH - 1);

  logic [arrsrt_pkg::DATA_W-1:0]  mem [DEPTH];
  logic [arrsrt_pkg::DATA_W-1:0]  rdata_q;

  logic [arrsrt_pkg::FUNC_W-1:0]  func_q;
  logic [arrsrt_pkg::INDEX_W-1:0] index_q;
  logic [arrsrt_pkg::DATA_W-1:0]  value_q;
  logic [CW-1:0]                  i_q, i_d, j_q, j_d;
  logic [arrsrt_pkg::DATA_W-1:0]  a_q;
  logic [arrsrt_pkg::DATA_W-1:0]  rd_q;
  logic                           found_q, err_q;
  logic                           svld_q;
  logic [AW-1:0]                  saddr_q;
  logic                           out_valid_q;
  logic [arrsrt_pkg::DATA_W-1:0]  out_data_q;
  logic [arrsrt_pkg::FLAGS_W-1:0] out_flags_q;

  logic [CW-1:0]                  n;
  logic [AW-1:0]                  raddr, waddr_cmd, waddr;
  logic [arrsrt_pkg::DATA_W-1:0]  wdata_cmd, wdata;
  logic                           mem_we, sort_wr, srch_hit;

  // Entries in use: the count register saturated to the store depth.
  assign n = (CW'(elem_count_i) > DEPTH_C) ? DEPTH_C : CW'(elem_count_i);

  always_comb begin
    case (cmd_i.rsel)
      arrsrt_pkg::RA_I:     raddr = i_q[AW-1:0];
      arrsrt_pkg::RA_J:     raddr = j_q[AW-1:0];
      arrsrt_pkg::RA_INDEX: raddr = AW'(index_q);
      default:              raddr = '0;
    endcase
    case (cmd_i.wsel)
      arrsrt_pkg::WA_I:     waddr_cmd = i_q[AW-1:0];
      arrsrt_pkg::WA_J:     waddr_cmd = j_q[AW-1:0];
      arrsrt_pkg::WA_INDEX: waddr_cmd = AW'(index_q);
      default:              waddr_cmd = '0;
    endcase
    case (cmd_i.wdsel)
      arrsrt_pkg::WD_VALUE: wdata_cmd = value_q;
      arrsrt_pkg::WD_A:     wdata_cmd = a_q;
      arrsrt_pkg::WD_RDATA: wdata_cmd = rdata_q;
      default:              wdata_cmd = '0;
    endcase
  end

  // Streamed reads come back in the next cycle; a sort step swaps when the held
  // value is larger than the entry just read.
  assign sort_wr  = svld_q && (func_q == arrsrt_pkg::FUNC_SORT) &&
                    ($signed(a_q) > $signed(rdata_q));
  assign srch_hit = svld_q && (func_q == arrsrt_pkg::FUNC_SEARCH) && (rdata_q == value_q);

  assign mem_we = cmd_i.we | sort_wr;
  assign waddr  = sort_wr ? saddr_q : waddr_cmd;
  assign wdata  = sort_wr ? a_q : wdata_cmd;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_comb begin
    i_d = i_q;
    if (cmd_i.i_clr) begin
      i_d = '0;
    end else if (cmd_i.i_inc) begin
      i_d = i_q + CW'(1);
    end
    j_d = j_q;
    if (cmd_i.j_clr) begin
      j_d = '0;
    end else if (cmd_i.j_ld_i1) begin
      j_d = i_q + CW'(1);
    end else if (cmd_i.j_ld_last) begin
      j_d = n - CW'(1);
    end else if (cmd_i.j_inc) begin
      j_d = j_q + CW'(1);
    end else if (cmd_i.j_dec) begin
      j_d = j_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q         <= '0;
      j_q         <= '0;
      svld_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      i_q    <= i_d;
      j_q    <= j_d;
      svld_q <= cmd_i.re && cmd_i.stream;
      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      func_q  <= in_func_i;
      index_q <= in_index_i;
      value_q <= in_value_i;
      rd_q    <= '0;
      found_q <= 1'b0;
      err_q   <= 1'b0;
    end else begin
      if (cmd_i.rd_ld) begin
        rd_q <= rdata_q;
      end
      if (srch_hit) begin
        found_q <= 1'b1;
      end
      if (cmd_i.err_set) begin
        err_q <= 1'b1;
      end
    end
    if (cmd_i.re) begin
      saddr_q <= raddr;
    end
    if (sort_wr || cmd_i.a_ld) begin
      a_q <= rdata_q;
    end
    if (cmd_i.push) begin
      out_data_q  <= rd_q;
      out_flags_q <= {(elem_count_i == '0), err_q, found_q};
    end
  end

  assign sts_o.func        = func_q;
  assign sts_o.idx_ok      = CW'(index_q) < n;
  assign sts_o.n_zero      = (n == '0);
  assign sts_o.n_lt2       = n < CW'(2);
  assign sts_o.i_next_lt_n = (i_q + CW'(1)) < n;
  assign sts_o.i_lt_j      = i_q < j_q;
  assign sts_o.j_at_last   = (j_q + CW'(1)) == n;
  assign sts_o.clr_last    = (i_q == CLR_LAST);
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_flags_o = out_flags_q;

  `SRT_ASSERT(a_push_slot_free, clk_i, rst_ni, cmd_i.push |-> (!out_valid_q || out_ready_i))
  `SRT_ASSERT_NEVER(a_write_collision, clk_i, rst_ni, cmd_i.we && sort_wr)
  `SRT_ASSERT(a_stream_in_range, clk_i, rst_ni, (cmd_i.re && cmd_i.stream) |-> (j_q < n))

endmodule

`default_nettype wire

### rtl/array_store_sort_search.sv
// Array store with write, read, fill, search, reverse and exchange sort.
// Users: send one request on the slave stream (tuser carries the operation, tdata the
//   index and value) and take one result per request from the master stream.
// The APB port holds the element count register at byte address 0; it must only be
//   written while no request is in flight.
// After reset the store is zeroed by a clearing pass over all DEPTH entries, during which no
//   request is accepted; configuration writes are taken at all times.
// Requests are handled one at a time. Fill, search, reverse and sort work on the first n
//   entries, where n is the count saturated to DEPTH; all but fill walk them through the
//   single read port of the entry memory.
// The result sits in an output register, so the next request is accepted while it waits;
//   when the receiver stalls, that next request is worked off and then held until the
//   output register is free.
// Depends on arrsrt_pkg, arrsrt_ctrl and arrsrt_dpath.
`default_nettype none

module array_store_sort_search #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Request stream.
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // tdata from bit 0: index [5:0], value [37:6], zero fill [39:38].
  input  logic [arrsrt_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  // tuser from bit 0: func [2:0].
  input  logic [arrsrt_pkg::FUNC_W-1:0]          s_axis_tuser_i,
  // Result stream.
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  // tdata from bit 0: read_data [31:0].
  output logic [arrsrt_pkg::DATA_W-1:0]          m_axis_tdata_o,
  // tuser from bit 0: found [0], index_error [1], store_empty [2].
  output logic [arrsrt_pkg::FLAGS_W-1:0]         m_axis_tuser_o,
  // Configuration port.
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [arrsrt_pkg::APB_AW-1:0]          paddr,
  input  logic [arrsrt_pkg::APB_DW-1:0]          pwdata,
  output logic [arrsrt_pkg::APB_DW-1:0]          prdata,
  output logic                                   pready
);

  logic [arrsrt_pkg::COUNT_W-1:0] elem_count_q;
  logic                           reg_sel;
  arrsrt_pkg::ctrl_cmd_t          cmd;
  arrsrt_pkg::ctrl_sts_t          sts;

  // The register index is the address divided by four; only index zero exists.
  assign reg_sel = (paddr[2] == arrsrt_pkg::REG_ELEM_COUNT);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? arrsrt_pkg::APB_DW'(elem_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_count_q <= arrsrt_pkg::ELEM_COUNT_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      elem_count_q <= pwdata[arrsrt_pkg::COUNT_W-1:0];
    end
  end

  arrsrt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  arrsrt_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .elem_count_i (elem_count_q),
    .in_func_i    (s_axis_tuser_i),
    .in_index_i   (s_axis_tdata_i[arrsrt_pkg::INDEX_W-1:0]),
    .in_value_i   (s_axis_tdata_i[arrsrt_pkg::INDEX_W +: arrsrt_pkg::DATA_W]),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_data_o   (m_axis_tdata_o),
    .out_flags_o  (m_axis_tuser_o)
  );

endmodule

`default_nettype wire
